// ===== hdl/sorted_priority_queue_unit_defines.svh =====
// Assertion macros for the sorted priority queue.
// Included by the top level; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Shared constants and types for the sorted priority queue.
// No dependencies.
`default_nettype none
package spq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int PRI_W       = 14;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;

    localparam logic [PRI_W-1:0] MAX_PRIORITY = PRI_W'(9999);

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    append;
        logic                    rem;
        logic signed [VAL_W-1:0] value;
        logic [PRI_W-1:0]        prio;
    } t_cell_cmd;
endpackage
`default_nettype wire

// ===== hdl/sorted_priority_queue_unit.sv =====
// Sorted priority queue: a chain of spq_cell slots kept in priority order.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_unit_defines.svh.
//
// Input channel: i_valid / o_stall carry an operation (append at the rear
// with priority 9999, insert by priority, remove front) with its value and
// priority. An item is taken at an edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result per item: the removed
// value (zero unless a remove succeeded), a status (ok, full, empty) and
// the occupancy after the operation.
// The result is registered at the edge that takes the item. Throughput
// is one item per cycle unless a result waits under i_stall; every slot
// compares its priority against the incoming one and shifts in the same
// cycle, so the chain of slots sets the pace, not any loop.
// While a result waits under i_stall, o_stall is high and nothing is taken.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared and are never read before being written.
`default_nettype none
`include "sorted_priority_queue_unit_defines.svh"
module sorted_priority_queue_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [spq_pkg::OP_W-1:0]          i_operation,
    input  wire logic signed [spq_pkg::VAL_W-1:0]  i_item_value,
    input  wire logic [spq_pkg::PRI_W-1:0]         i_item_priority,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [spq_pkg::VAL_W-1:0]       o_removed_value,
    output logic [spq_pkg::ST_W-1:0]               o_status,
    output logic [spq_pkg::CNT_W-1:0]              o_occupancy
);
    localparam int N = spq_pkg::QUEUE_DEPTH;

    logic [spq_pkg::CNT_W-1:0]        r_count, n_count;
    logic                             r_out_valid;
    logic signed [spq_pkg::VAL_W-1:0] r_out_value, n_out_value;
    logic [spq_pkg::ST_W-1:0]         r_out_status, n_out_status;

    logic fire, is_enq, is_rem, full, empty;
    spq_pkg::t_cell_cmd cmd;

    logic                             w_ge    [N];
    logic signed [spq_pkg::VAL_W-1:0] w_value [N];
    logic [spq_pkg::PRI_W-1:0]        w_prio  [N];

    assign o_stall = r_out_valid && i_stall;
    assign fire    = i_valid && !o_stall;
    assign is_enq  = (i_operation == spq_pkg::OP_APPEND) ||
                     (i_operation == spq_pkg::OP_INSERT);
    assign is_rem  = (i_operation == spq_pkg::OP_REMOVE);
    assign full    = (r_count == spq_pkg::CNT_W'(N));
    assign empty   = (r_count == '0);

    always_comb begin
        cmd.ins    = fire && is_enq && !full;
        cmd.append = (i_operation == spq_pkg::OP_APPEND);
        cmd.rem    = fire && is_rem && !empty;
        cmd.value  = i_item_value;
        if (cmd.append || (i_item_priority > spq_pkg::MAX_PRIORITY)) begin
            cmd.prio = spq_pkg::MAX_PRIORITY;
        end else begin
            cmd.prio = i_item_priority;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic                             left_ge;
        logic signed [spq_pkg::VAL_W-1:0] left_value, right_value;
        logic [spq_pkg::PRI_W-1:0]        left_prio, right_prio;

        if (g == 0) begin : g_head
            assign left_ge    = 1'b0;
            assign left_value = '0;
            assign left_prio  = '0;
        end else begin : g_body
            assign left_ge    = w_ge[g-1];
            assign left_value = w_value[g-1];
            assign left_prio  = w_prio[g-1];
        end
        if (g == N - 1) begin : g_tail
            assign right_value = '0;
            assign right_prio  = '0;
        end else begin : g_mid
            assign right_value = w_value[g+1];
            assign right_prio  = w_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_occupied    (r_count > spq_pkg::CNT_W'(g)),
            .i_left_ge     (left_ge),
            .i_left_value  (left_value),
            .i_left_prio   (left_prio),
            .i_right_value (right_value),
            .i_right_prio  (right_prio),
            .o_ge          (w_ge[g]),
            .o_value       (w_value[g]),
            .o_prio        (w_prio[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = spq_pkg::ST_OK;
        if (cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (cmd.rem) begin
            n_count     = r_count - 1'b1;
            n_out_value = w_value[0];
        end
        if (is_enq && full) begin
            n_out_status = spq_pkg::ST_FULL;
        end else if (is_rem && empty) begin
            n_out_status = spq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_out_value;
    assign o_status        = r_out_status;
    assign o_occupancy     = r_count;

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= spq_pkg::CNT_W'(N), "occupancy above depth")
    `SPQ_ASSERT_NEXT(a_count_idle, i_clk, i_rst_n, !fire, $stable(r_count), "occupancy moved without an item")
    `SPQ_ASSERT_NEXT(a_empty_rem, i_clk, i_rst_n, fire && is_rem && empty, o_status == spq_pkg::ST_EMPTY && o_occupancy == '0, "remove on empty not flagged")
    `SPQ_ASSERT_NEXT(a_full_ins, i_clk, i_rst_n, fire && is_enq && full, o_status == spq_pkg::ST_FULL && $stable(r_count), "insert on full not dropped")
endmodule
`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One slot of the sorted queue chain: holds a value and its priority.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
    input  wire logic                            i_clk,
    input  wire spq_pkg::t_cell_cmd              i_cmd,
    input  wire logic                            i_occupied,
    input  wire logic                            i_left_ge,
    input  wire logic signed [spq_pkg::VAL_W-1:0] i_left_value,
    input  wire logic [spq_pkg::PRI_W-1:0]       i_left_prio,
    input  wire logic signed [spq_pkg::VAL_W-1:0] i_right_value,
    input  wire logic [spq_pkg::PRI_W-1:0]       i_right_prio,
    output logic                                 o_ge,
    output logic signed [spq_pkg::VAL_W-1:0]     o_value,
    output logic [spq_pkg::PRI_W-1:0]            o_prio
);
    logic signed [spq_pkg::VAL_W-1:0] r_value, n_value;
    logic [spq_pkg::PRI_W-1:0]        r_prio, n_prio;

    // Entries stay sorted, so this flag is monotonic along the chain.
    assign o_ge    = !i_occupied || (!i_cmd.append && (r_prio >= i_cmd.prio));
    assign o_value = r_value;
    assign o_prio  = r_prio;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.ins && o_ge) begin
            if (i_left_ge) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else begin
                n_value = i_cmd.value;
                n_prio  = i_cmd.prio;
            end
        end else if (i_cmd.rem) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end
endmodule
`default_nettype wire
